FILE: sv/sfcs_pkg.sv
package sfcs_pkg;

    // Address bytes sent after a program, read or erase command.
    localparam int unsigned ADDR_BYTES = 3;

    // Input function codes.
    localparam logic [1:0] FUNC_START = 2'd0;
    localparam logic [1:0] FUNC_HOST  = 2'd1;
    localparam logic [1:0] FUNC_SPI   = 2'd2;

    // Operation codes carried by a start transfer.
    localparam logic [1:0] OP_WRSR  = 2'd0;
    localparam logic [1:0] OP_PROG  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_ERASE = 2'd3;

    // Result kinds.
    localparam logic [1:0] KIND_XFER = 2'd0;
    localparam logic [1:0] KIND_HOST = 2'd1;
    localparam logic [1:0] KIND_DONE = 2'd2;

    // Flash command bytes.
    localparam logic [7:0] CMD_RDSR  = 8'h05;
    localparam logic [7:0] CMD_WREN  = 8'h06;
    localparam logic [7:0] CMD_WRSR  = 8'h01;
    localparam logic [7:0] CMD_PP    = 8'h02;
    localparam logic [7:0] CMD_FREAD = 8'h0B;
    localparam logic [7:0] CMD_SE    = 8'h20;
    localparam logic [7:0] BYTE_IDLE = 8'hFF;

    // Status register bits.
    localparam int unsigned SR_WIP = 0;
    localparam int unsigned SR_WEL = 1;

    // Header lengths in bytes, per operation.
    localparam logic [2:0] HDR_LEN_WRSR = 3'd2;
    localparam logic [2:0] HDR_LEN_READ = 3'(2 + ADDR_BYTES);
    localparam logic [2:0] HDR_LEN_ADDR = 3'(1 + ADDR_BYTES);

    // Result queue geometry.
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Sequencer phases, one-hot.
    typedef enum logic [9:0] {
        PH_IDLE      = 10'b00_0000_0001,
        PH_WREN      = 10'b00_0000_0010,
        PH_WEL_CMD   = 10'b00_0000_0100,
        PH_WEL_READ  = 10'b00_0000_1000,
        PH_HEADER    = 10'b00_0001_0000,
        PH_WAIT_HOST = 10'b00_0010_0000,
        PH_PROG_DATA = 10'b00_0100_0000,
        PH_READ_DATA = 10'b00_1000_0000,
        PH_WIP_CMD   = 10'b01_0000_0000,
        PH_WIP_READ  = 10'b10_0000_0000
    } t_phase;

    // One result item.
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] tx_byte;
        logic       cs_active;
        logic       end_frame;
        logic [7:0] rx_data;
        logic       last;
    } t_result;

    // A transfer request with chip select held low.
    function automatic t_result make_xfer(logic [7:0] tx, logic endf);
        t_result r;
        r           = '0;
        r.kind      = KIND_XFER;
        r.tx_byte   = tx;
        r.cs_active = 1'b1;
        r.end_frame = endf;
        r.last      = 1'b1;
        return r;
    endfunction

    // A byte handed to the host; a further result always follows it.
    function automatic t_result make_host(logic [7:0] rx);
        t_result r;
        r         = '0;
        r.kind    = KIND_HOST;
        r.rx_data = rx;
        return r;
    endfunction

    // The end of an operation.
    function automatic t_result make_done();
        t_result r;
        r      = '0;
        r.kind = KIND_DONE;
        r.last = 1'b1;
        return r;
    endfunction

endpackage

FILE: sv/sfcs_in_if.sv
interface sfcs_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [1:0]  op;
    logic [23:0] flash_addr;
    logic [15:0] byte_count;
    logic [7:0]  byte_value;

    modport source (
        output valid, func, op, flash_addr, byte_count, byte_value,
        input  ready
    );

    modport sink (
        input  valid, func, op, flash_addr, byte_count, byte_value,
        output ready
    );
endinterface

FILE: sv/sfcs_out_if.sv
interface sfcs_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] tx_byte;
    logic       cs_active;
    logic       end_frame;
    logic [7:0] rx_data;
    logic       last;

    modport source (
        output valid, kind, tx_byte, cs_active, end_frame, rx_data, last,
        input  ready
    );

    modport sink (
        input  valid, kind, tx_byte, cs_active, end_frame, rx_data, last,
        output ready
    );
endinterface

FILE: sv/spi_flash_command_sequencer.sv
// SPI NOR flash command sequencer, 25-series command set.
// Results of an input transfer are written into the registered result queue.
// Throughput: one input transfer per cycle while the queue has room; a read data
// byte yields two results, so reads run at one result per cycle unless stalled.
// Reset: synchronous, active low; clears the phase, operation state and queue.
module spi_flash_command_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sfcs_in_if.sink     i_in,
    sfcs_out_if.source  o_out
);

    logic                              w_take;
    logic [1:0]                        w_count;
    sfcs_pkg::t_result                 w_res0;
    sfcs_pkg::t_result                 w_res1;
    sfcs_pkg::t_result                 w_head;
    logic                              w_space;
    logic [sfcs_pkg::QUEUE_CNT_W-1:0]  w_level;

    assign i_in.ready = w_space;
    assign w_take     = i_in.valid && i_in.ready;

    // Sequencer step and state.
    sfcs_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (w_take),
        .i_func       (i_in.func),
        .i_op         (i_in.op),
        .i_flash_addr (i_in.flash_addr),
        .i_byte_count (i_in.byte_count),
        .i_byte_value (i_in.byte_value),
        .o_count      (w_count),
        .o_res0       (w_res0),
        .o_res1       (w_res1)
    );

    // Registered result queue between the sequencer and the output.
    sfcs_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_n (w_count),
        .i_res0   (w_res0),
        .i_res1   (w_res1),
        .i_pop    (o_out.ready),
        .o_space  (w_space),
        .o_valid  (o_out.valid),
        .o_head   (w_head),
        .o_level  (w_level)
    );

    assign o_out.kind      = w_head.kind;
    assign o_out.tx_byte   = w_head.tx_byte;
    assign o_out.cs_active = w_head.cs_active;
    assign o_out.end_frame = w_head.end_frame;
    assign o_out.rx_data   = w_head.rx_data;
    assign o_out.last      = w_head.last;

    // The queue never overfills after an input transfer.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |=> (w_level <= sfcs_pkg::QUEUE_CNT_W'(sfcs_pkg::QUEUE_DEPTH)))
        else $error("result queue overflow");

    // A host byte is never the last result and its follower is already queued.
    a_host_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.kind == sfcs_pkg::KIND_HOST))
        |-> (!o_out.last && (w_level >= sfcs_pkg::QUEUE_CNT_W'(2))))
        else $error("host byte without a following result");

    // Completion always closes the results of its input transfer.
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.kind == sfcs_pkg::KIND_DONE))
        |-> (o_out.last && !o_out.cs_active))
        else $error("done result malformed");

    // Every transfer request holds chip select low.
    a_xfer_cs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.kind == sfcs_pkg::KIND_XFER))
        |-> (o_out.cs_active && o_out.last))
        else $error("transfer request without chip select");

endmodule

FILE: sv/sfcs_core.sv
module sfcs_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_take,
    input  logic [1:0]            i_func,
    input  logic [1:0]            i_op,
    input  logic [23:0]           i_flash_addr,
    input  logic [15:0]           i_byte_count,
    input  logic [7:0]            i_byte_value,
    output logic [1:0]            o_count,
    output sfcs_pkg::t_result     o_res0,
    output sfcs_pkg::t_result     o_res1
);

    sfcs_pkg::t_phase r_phase, n_phase;
    logic [1:0]       r_op, n_op;
    logic [23:0]      r_addr, n_addr;
    logic [15:0]      r_left, n_left;
    logic [7:0]       r_status, n_status;
    logic [2:0]       r_hdr, n_hdr;

    logic [15:0]      w_left_dec;
    logic [2:0]       w_hdr_inc;

    // Number of header bytes for an operation.
    function automatic logic [2:0] hdr_len(logic [1:0] op);
        logic [2:0] len;
        if (op == sfcs_pkg::OP_WRSR) begin
            len = sfcs_pkg::HDR_LEN_WRSR;
        end else if (op == sfcs_pkg::OP_READ) begin
            len = sfcs_pkg::HDR_LEN_READ;
        end else begin
            len = sfcs_pkg::HDR_LEN_ADDR;
        end
        return len;
    endfunction

    // Header byte at a position: command, then status or address, then dummy.
    function automatic logic [7:0] hdr_byte(logic [1:0] op, logic [23:0] addr,
                                            logic [7:0] stat, logic [2:0] idx);
        logic [7:0] b;
        if (idx == 3'd0) begin
            unique case (op)
                sfcs_pkg::OP_WRSR: b = sfcs_pkg::CMD_WRSR;
                sfcs_pkg::OP_PROG: b = sfcs_pkg::CMD_PP;
                sfcs_pkg::OP_READ: b = sfcs_pkg::CMD_FREAD;
                default:           b = sfcs_pkg::CMD_SE;
            endcase
        end else if (op == sfcs_pkg::OP_WRSR) begin
            b = stat;
        end else if (idx == 3'd1) begin
            b = addr[23:16];
        end else if (idx == 3'd2) begin
            b = addr[15:8];
        end else if (idx == 3'd3) begin
            b = addr[7:0];
        end else begin
            b = sfcs_pkg::BYTE_IDLE;
        end
        return b;
    endfunction

    // Header transfer; the frame closes on the last header byte unless data follows.
    function automatic sfcs_pkg::t_result hdr_xfer(logic [1:0] op, logic [23:0] addr,
                                                   logic [7:0] stat, logic [2:0] idx,
                                                   logic [15:0] left);
        logic data_follows;
        logic endf;
        data_follows = ((op == sfcs_pkg::OP_PROG) || (op == sfcs_pkg::OP_READ))
                       && (left != 16'd0);
        endf = (({1'b0, idx} + 4'd1) >= {1'b0, hdr_len(op)}) && !data_follows;
        return sfcs_pkg::make_xfer(hdr_byte(op, addr, stat, idx), endf);
    endfunction

    assign w_left_dec = r_left - 16'd1;
    assign w_hdr_inc  = r_hdr + 3'd1;

    // One step of the sequencer for the transfer being taken.
    always_comb begin
        n_phase  = r_phase;
        n_op     = r_op;
        n_addr   = r_addr;
        n_left   = r_left;
        n_status = r_status;
        n_hdr    = r_hdr;
        o_count  = 2'd0;
        o_res0   = '0;
        o_res1   = '0;
        if (i_take) begin
            if (i_func == sfcs_pkg::FUNC_START) begin
                if (r_phase == sfcs_pkg::PH_IDLE) begin
                    n_op     = i_op;
                    n_addr   = i_flash_addr;
                    n_left   = i_byte_count;
                    n_status = i_byte_value;
                    n_hdr    = 3'd0;
                    o_count  = 2'd1;
                    if (i_op == sfcs_pkg::OP_READ) begin
                        n_phase = sfcs_pkg::PH_HEADER;
                        o_res0  = hdr_xfer(i_op, i_flash_addr, i_byte_value, 3'd0,
                                           i_byte_count);
                    end else begin
                        n_phase = sfcs_pkg::PH_WREN;
                        o_res0  = sfcs_pkg::make_xfer(sfcs_pkg::CMD_WREN, 1'b1);
                    end
                end
            end else if (i_func == sfcs_pkg::FUNC_HOST) begin
                if (r_phase == sfcs_pkg::PH_WAIT_HOST) begin
                    o_count = 2'd1;
                    o_res0  = sfcs_pkg::make_xfer(i_byte_value, r_left == 16'd1);
                    n_left  = w_left_dec;
                    n_phase = sfcs_pkg::PH_PROG_DATA;
                end
            end else if (i_func == sfcs_pkg::FUNC_SPI) begin
                unique case (r_phase)
                    sfcs_pkg::PH_WREN: begin
                        n_phase = sfcs_pkg::PH_WEL_CMD;
                        o_count = 2'd1;
                        o_res0  = sfcs_pkg::make_xfer(sfcs_pkg::CMD_RDSR, 1'b0);
                    end
                    sfcs_pkg::PH_WEL_CMD: begin
                        n_phase = sfcs_pkg::PH_WEL_READ;
                        o_count = 2'd1;
                        o_res0  = sfcs_pkg::make_xfer(sfcs_pkg::BYTE_IDLE, 1'b1);
                    end
                    sfcs_pkg::PH_WEL_READ: begin
                        o_count = 2'd1;
                        if (i_byte_value[sfcs_pkg::SR_WEL]) begin
                            n_phase = sfcs_pkg::PH_HEADER;
                            n_hdr   = 3'd0;
                            o_res0  = hdr_xfer(r_op, r_addr, r_status, 3'd0, r_left);
                        end else begin
                            n_phase = sfcs_pkg::PH_WEL_CMD;
                            o_res0  = sfcs_pkg::make_xfer(sfcs_pkg::CMD_RDSR, 1'b0);
                        end
                    end
                    sfcs_pkg::PH_HEADER: begin
                        n_hdr = w_hdr_inc;
                        if (w_hdr_inc < hdr_len(r_op)) begin
                            o_count = 2'd1;
                            o_res0  = hdr_xfer(r_op, r_addr, r_status, w_hdr_inc, r_left);
                        end else if (r_op == sfcs_pkg::OP_READ) begin
                            o_count = 2'd1;
                            if (r_left == 16'd0) begin
                                n_phase = sfcs_pkg::PH_IDLE;
                                o_res0  = sfcs_pkg::make_done();
                            end else begin
                                n_phase = sfcs_pkg::PH_READ_DATA;
                                o_res0  = sfcs_pkg::make_xfer(sfcs_pkg::BYTE_IDLE,
                                                              r_left == 16'd1);
                            end
                        end else if ((r_op == sfcs_pkg::OP_PROG) && (r_left != 16'd0)) begin
                            n_phase = sfcs_pkg::PH_WAIT_HOST;
                        end else begin
                            n_phase = sfcs_pkg::PH_WIP_CMD;
                            o_count = 2'd1;
                            o_res0  = sfcs_pkg::make_xfer(sfcs_pkg::CMD_RDSR, 1'b0);
                        end
                    end
                    sfcs_pkg::PH_PROG_DATA: begin
                        if (r_left != 16'd0) begin
                            n_phase = sfcs_pkg::PH_WAIT_HOST;
                        end else begin
                            n_phase = sfcs_pkg::PH_WIP_CMD;
                            o_count = 2'd1;
                            o_res0  = sfcs_pkg::make_xfer(sfcs_pkg::CMD_RDSR, 1'b0);
                        end
                    end
                    sfcs_pkg::PH_READ_DATA: begin
                        o_count = 2'd2;
                        o_res0  = sfcs_pkg::make_host(i_byte_value);
                        n_left  = w_left_dec;
                        if (w_left_dec != 16'd0) begin
                            o_res1 = sfcs_pkg::make_xfer(sfcs_pkg::BYTE_IDLE,
                                                         w_left_dec == 16'd1);
                        end else begin
                            n_phase = sfcs_pkg::PH_IDLE;
                            o_res1  = sfcs_pkg::make_done();
                        end
                    end
                    sfcs_pkg::PH_WIP_CMD: begin
                        n_phase = sfcs_pkg::PH_WIP_READ;
                        o_count = 2'd1;
                        o_res0  = sfcs_pkg::make_xfer(sfcs_pkg::BYTE_IDLE, 1'b1);
                    end
                    sfcs_pkg::PH_WIP_READ: begin
                        o_count = 2'd1;
                        if (i_byte_value[sfcs_pkg::SR_WIP]) begin
                            n_phase = sfcs_pkg::PH_WIP_CMD;
                            o_res0  = sfcs_pkg::make_xfer(sfcs_pkg::CMD_RDSR, 1'b0);
                        end else begin
                            n_phase = sfcs_pkg::PH_IDLE;
                            o_res0  = sfcs_pkg::make_done();
                        end
                    end
                    sfcs_pkg::PH_IDLE, sfcs_pkg::PH_WAIT_HOST: begin
                        // A returned byte is not expected here and is dropped.
                    end
                    default: begin
                        n_phase = sfcs_pkg::PH_IDLE;
                    end
                endcase
            end
        end
    end

    // Sequencer state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= sfcs_pkg::PH_IDLE;
            r_op     <= '0;
            r_addr   <= '0;
            r_left   <= '0;
            r_status <= '0;
            r_hdr    <= '0;
        end else begin
            r_phase  <= n_phase;
            r_op     <= n_op;
            r_addr   <= n_addr;
            r_left   <= n_left;
            r_status <= n_status;
            r_hdr    <= n_hdr;
        end
    end

endmodule

FILE: sv/sfcs_queue.sv
module sfcs_queue (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [1:0]                          i_push_n,
    input  sfcs_pkg::t_result                   i_res0,
    input  sfcs_pkg::t_result                   i_res1,
    input  logic                                i_pop,
    output logic                                o_space,
    output logic                                o_valid,
    output sfcs_pkg::t_result                   o_head,
    output logic [sfcs_pkg::QUEUE_CNT_W-1:0]    o_level
);

    localparam int unsigned PTR_W = sfcs_pkg::QUEUE_PTR_W;
    localparam int unsigned CNT_W = sfcs_pkg::QUEUE_CNT_W;

    sfcs_pkg::t_result r_mem [sfcs_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr, n_wr;
    logic [PTR_W-1:0]  r_rd, n_rd;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              w_pop;

    // Room for the largest burst of results that one input transfer causes.
    assign o_space = r_count <= CNT_W'(sfcs_pkg::QUEUE_DEPTH - 2);
    assign o_valid = r_count != '0;
    assign o_head  = r_mem[r_rd];
    assign o_level = r_count;
    assign w_pop   = o_valid && i_pop;

    // Pointer and fill level bookkeeping.
    always_comb begin
        n_wr    = r_wr + PTR_W'(i_push_n);
        n_rd    = r_rd + PTR_W'(w_pop);
        n_count = r_count + CNT_W'(i_push_n) - CNT_W'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // Result storage; entries need no reset.
    always_ff @(posedge i_clk) begin
        if (i_push_n != 2'd0) begin
            r_mem[r_wr] <= i_res0;
        end
        if (i_push_n == 2'd2) begin
            r_mem[r_wr + PTR_W'(1)] <= i_res1;
        end
    end

endmodule

FILE: sim/tb_spi_flash_command_sequencer.sv
module tb_spi_flash_command_sequencer;
    timeunit 1ns;
    timeprecision 1ps;

    // Function code with no meaning to the sequencer.
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    // A table row whose results come from the predictor rather than being typed in.
    localparam int PREDICTED    = -1;
    localparam int RANDOM_ITEMS = 925;
    localparam int DRAIN_LIMIT  = 2000;
    localparam int TAIL_CYCLES  = 16;

    typedef struct packed {
        logic [1:0]  func;
        logic [1:0]  op;
        logic [23:0] flash_addr;
        logic [15:0] byte_count;
        logic [7:0]  byte_value;
    } t_flash_req;

    typedef struct {
        t_flash_req          req;
        int                  typed;
        sfcs_pkg::t_result   res;
    } t_stim_row;

    logic i_clk      = 1'b0;
    logic i_rst_n    = 1'b0;
    logic sink_ready = 1'b0;

    sfcs_in_if  in_if ();
    sfcs_out_if out_if ();

    assign out_if.ready = sink_ready;

    spi_flash_command_sequencer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #6 i_clk = ~i_clk;

    // Predicted sequencer state.
    sfcs_pkg::t_phase seq_phase  = sfcs_pkg::PH_IDLE;
    logic [1:0]       seq_op     = '0;
    logic [23:0]      seq_addr   = '0;
    logic [15:0]      seq_left   = '0;
    logic [7:0]       seq_status = '0;
    logic [2:0]       seq_hidx   = '0;

    sfcs_pkg::t_result expected_results[$];
    t_stim_row         stim_table[$];
    int                mismatches = 0;

    function automatic sfcs_pkg::t_result pack_result(logic [1:0] kind, logic [7:0] tx,
                                                      logic endf, logic [7:0] rx,
                                                      logic lst);
        sfcs_pkg::t_result r;
        r.kind      = kind;
        r.tx_byte   = tx;
        r.cs_active = (kind == sfcs_pkg::KIND_XFER);
        r.end_frame = endf;
        r.rx_data   = rx;
        r.last      = lst;
        return r;
    endfunction

    function automatic int header_len();
        if (seq_op == sfcs_pkg::OP_WRSR) return 2;
        if (seq_op == sfcs_pkg::OP_READ) return 2 + sfcs_pkg::ADDR_BYTES;
        return 1 + sfcs_pkg::ADDR_BYTES;
    endfunction

    // Command byte, then the status value or the address (most significant first), then dummy.
    function automatic logic [7:0] header_byte(int idx);
        if (idx == 0) begin
            case (seq_op)
                sfcs_pkg::OP_WRSR: return sfcs_pkg::CMD_WRSR;
                sfcs_pkg::OP_PROG: return sfcs_pkg::CMD_PP;
                sfcs_pkg::OP_READ: return sfcs_pkg::CMD_FREAD;
                default:           return sfcs_pkg::CMD_SE;
            endcase
        end
        if (seq_op == sfcs_pkg::OP_WRSR) return seq_status;
        if (idx <= int'(sfcs_pkg::ADDR_BYTES))
            return 8'(seq_addr >> (8 * (int'(sfcs_pkg::ADDR_BYTES) - idx)));
        return sfcs_pkg::BYTE_IDLE;
    endfunction

    // The frame closes on the last header byte unless data bytes follow it.
    function automatic sfcs_pkg::t_result header_result();
        logic data_follows;
        logic endf;
        data_follows = (seq_op == sfcs_pkg::OP_PROG || seq_op == sfcs_pkg::OP_READ)
                       && seq_left != 0;
        endf         = (int'(seq_hidx) + 1 >= header_len()) && !data_follows;
        return pack_result(sfcs_pkg::KIND_XFER, header_byte(int'(seq_hidx)), endf,
                           8'h00, 1'b1);
    endfunction

    function automatic sfcs_pkg::t_result rdsr_result(logic endf, logic [7:0] tx);
        return pack_result(sfcs_pkg::KIND_XFER, tx, endf, 8'h00, 1'b1);
    endfunction

    function automatic sfcs_pkg::t_result done_result();
        return pack_result(sfcs_pkg::KIND_DONE, 8'h00, 1'b0, 8'h00, 1'b1);
    endfunction

    // Advances the predicted state by one accepted transfer; returns the number of results.
    function automatic int sequence_step(t_flash_req rq, output sfcs_pkg::t_result r0,
                                         output sfcs_pkg::t_result r1);
        r0 = '0;
        r1 = '0;
        if (rq.func == sfcs_pkg::FUNC_START) begin
            if (seq_phase != sfcs_pkg::PH_IDLE) return 0;
            seq_op     = rq.op;
            seq_addr   = rq.flash_addr;
            seq_left   = rq.byte_count;
            seq_status = rq.byte_value;
            seq_hidx   = '0;
            if (seq_op == sfcs_pkg::OP_READ) begin
                seq_phase = sfcs_pkg::PH_HEADER;
                r0        = header_result();
            end else begin
                seq_phase = sfcs_pkg::PH_WREN;
                r0        = rdsr_result(1'b1, sfcs_pkg::CMD_WREN);
            end
            return 1;
        end
        if (rq.func == sfcs_pkg::FUNC_HOST) begin
            if (seq_phase != sfcs_pkg::PH_WAIT_HOST) return 0;
            r0        = pack_result(sfcs_pkg::KIND_XFER, rq.byte_value, seq_left == 16'd1,
                                    8'h00, 1'b1);
            seq_left  = seq_left - 16'd1;
            seq_phase = sfcs_pkg::PH_PROG_DATA;
            return 1;
        end
        if (rq.func != sfcs_pkg::FUNC_SPI) return 0;

        // A returned spi byte moves the sequence on.
        case (seq_phase)
            sfcs_pkg::PH_WREN: begin
                seq_phase = sfcs_pkg::PH_WEL_CMD;
                r0        = rdsr_result(1'b0, sfcs_pkg::CMD_RDSR);
            end
            sfcs_pkg::PH_WEL_CMD: begin
                seq_phase = sfcs_pkg::PH_WEL_READ;
                r0        = rdsr_result(1'b1, sfcs_pkg::BYTE_IDLE);
            end
            sfcs_pkg::PH_WEL_READ: begin
                if (rq.byte_value[sfcs_pkg::SR_WEL]) begin
                    seq_phase = sfcs_pkg::PH_HEADER;
                    seq_hidx  = '0;
                    r0        = header_result();
                end else begin
                    seq_phase = sfcs_pkg::PH_WEL_CMD;
                    r0        = rdsr_result(1'b0, sfcs_pkg::CMD_RDSR);
                end
            end
            sfcs_pkg::PH_HEADER: begin
                seq_hidx = seq_hidx + 3'd1;
                if (int'(seq_hidx) < header_len()) begin
                    r0 = header_result();
                end else if (seq_op == sfcs_pkg::OP_READ) begin
                    if (seq_left == 0) begin
                        seq_phase = sfcs_pkg::PH_IDLE;
                        r0        = done_result();
                    end else begin
                        seq_phase = sfcs_pkg::PH_READ_DATA;
                        r0        = rdsr_result(seq_left == 16'd1, sfcs_pkg::BYTE_IDLE);
                    end
                end else if (seq_op == sfcs_pkg::OP_PROG && seq_left != 0) begin
                    seq_phase = sfcs_pkg::PH_WAIT_HOST;
                    return 0;
                end else begin
                    seq_phase = sfcs_pkg::PH_WIP_CMD;
                    r0        = rdsr_result(1'b0, sfcs_pkg::CMD_RDSR);
                end
            end
            sfcs_pkg::PH_PROG_DATA: begin
                if (seq_left != 0) begin
                    seq_phase = sfcs_pkg::PH_WAIT_HOST;
                    return 0;
                end
                seq_phase = sfcs_pkg::PH_WIP_CMD;
                r0        = rdsr_result(1'b0, sfcs_pkg::CMD_RDSR);
            end
            sfcs_pkg::PH_READ_DATA: begin
                r0       = pack_result(sfcs_pkg::KIND_HOST, 8'h00, 1'b0, rq.byte_value,
                                       1'b0);
                seq_left = seq_left - 16'd1;
                if (seq_left != 0) begin
                    r1 = rdsr_result(seq_left == 16'd1, sfcs_pkg::BYTE_IDLE);
                end else begin
                    seq_phase = sfcs_pkg::PH_IDLE;
                    r1        = done_result();
                end
                return 2;
            end
            sfcs_pkg::PH_WIP_CMD: begin
                seq_phase = sfcs_pkg::PH_WIP_READ;
                r0        = rdsr_result(1'b1, sfcs_pkg::BYTE_IDLE);
            end
            sfcs_pkg::PH_WIP_READ: begin
                if (rq.byte_value[sfcs_pkg::SR_WIP]) begin
                    seq_phase = sfcs_pkg::PH_WIP_CMD;
                    r0        = rdsr_result(1'b0, sfcs_pkg::CMD_RDSR);
                end else begin
                    seq_phase = sfcs_pkg::PH_IDLE;
                    r0        = done_result();
                end
            end
            default: return 0;
        endcase
        return 1;
    endfunction

    // Picks the next transfer from the predicted phase, acting as host and flash at once.
    function automatic t_flash_req next_request(bit noise);
        t_flash_req rq;
        rq.func       = sfcs_pkg::FUNC_SPI;
        rq.op         = 2'($urandom_range(0, 3));
        rq.flash_addr = 24'($urandom);
        rq.byte_count = 16'($urandom);
        rq.byte_value = 8'($urandom);
        if (noise) begin
            rq.func = 2'($urandom_range(0, 3));
            // A start while idle would begin an operation of any length.
            if (seq_phase == sfcs_pkg::PH_IDLE && rq.func == sfcs_pkg::FUNC_START)
                rq.func = FUNC_UNUSED;
            return rq;
        end
        case (seq_phase)
            sfcs_pkg::PH_IDLE: begin
                rq.func = sfcs_pkg::FUNC_START;
                case ($urandom_range(0, 7))
                    0:       rq.flash_addr = '0;
                    1:       rq.flash_addr = '1;
                    default: ;
                endcase
                // Data lengths stay short; write status and erase keep the full random count.
                if (rq.op == sfcs_pkg::OP_PROG || rq.op == sfcs_pkg::OP_READ) begin
                    if ($urandom_range(0, 19) == 0) rq.byte_count = 16'($urandom_range(9, 40));
                    else                            rq.byte_count = 16'($urandom_range(0, 8));
                end
            end
            sfcs_pkg::PH_WAIT_HOST: rq.func = sfcs_pkg::FUNC_HOST;
            sfcs_pkg::PH_WEL_READ:
                rq.byte_value[sfcs_pkg::SR_WEL] = ($urandom_range(0, 3) != 0);
            sfcs_pkg::PH_WIP_READ:
                rq.byte_value[sfcs_pkg::SR_WIP] = ($urandom_range(0, 2) == 0);
            default: ;
        endcase
        return rq;
    endfunction

    task automatic add_row(logic [1:0] func, logic [1:0] op, logic [23:0] addr,
                           logic [15:0] cnt, logic [7:0] val, int typed,
                           sfcs_pkg::t_result res);
        t_stim_row row;
        row.req   = '{func, op, addr, cnt, val};
        row.typed = typed;
        row.res   = res;
        stim_table.push_back(row);
    endtask

    // Holds one transfer on the input channel until it is taken.
    task automatic drive_request(t_flash_req rq, bit calm);
        int gap;
        gap = calm ? 0 : int'($urandom_range(0, 3));
        if (gap != 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid      <= 1'b1;
        in_if.func       <= rq.func;
        in_if.op         <= rq.op;
        in_if.flash_addr <= rq.flash_addr;
        in_if.byte_count <= rq.byte_count;
        in_if.byte_value <= rq.byte_value;
        do @(posedge i_clk); while (!in_if.ready);
    endtask

    // Typed rows replace the predicted results; the predicted state advances either way.
    task automatic record_request(t_flash_req rq, int typed, sfcs_pkg::t_result typed_res);
        int                n;
        sfcs_pkg::t_result r0;
        sfcs_pkg::t_result r1;
        n = sequence_step(rq, r0, r1);
        if (typed != PREDICTED) begin
            n  = typed;
            r0 = typed_res;
        end
        if (n > 0) expected_results.push_back(r0);
        if (n > 1) expected_results.push_back(r1);
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
        mismatches++;
    endtask

    // Result checker: every transfer on the output is matched against the oldest expectation.
    always @(posedge i_clk) begin
        sfcs_pkg::t_result got;
        sfcs_pkg::t_result want;
        if (i_rst_n && out_if.valid && sink_ready) begin
            got.kind      = out_if.kind;
            got.tx_byte   = out_if.tx_byte;
            got.cs_active = out_if.cs_active;
            got.end_frame = out_if.end_frame;
            got.rx_data   = out_if.rx_data;
            got.last      = out_if.last;
            if (expected_results.size() == 0) begin
                report_mismatch("result with nothing expected, kind", int'(got.kind), 0);
            end else begin
                want = expected_results.pop_front();
                if (got.kind !== want.kind)
                    report_mismatch("kind", int'(got.kind), int'(want.kind));
                if (got.tx_byte !== want.tx_byte)
                    report_mismatch("tx_byte", int'(got.tx_byte), int'(want.tx_byte));
                if (got.cs_active !== want.cs_active)
                    report_mismatch("cs_active", int'(got.cs_active), int'(want.cs_active));
                if (got.end_frame !== want.end_frame)
                    report_mismatch("end_frame", int'(got.end_frame), int'(want.end_frame));
                if (got.rx_data !== want.rx_data)
                    report_mismatch("rx_data", int'(got.rx_data), int'(want.rx_data));
                if (got.last !== want.last)
                    report_mismatch("last", int'(got.last), int'(want.last));
            end
        end
    end

    // Output back-pressure: a random stall after each transfer, with calm stretches.
    int sink_hold  = 0;
    int sink_count = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sink_ready <= 1'b0;
        end else if (out_if.valid && sink_ready) begin
            sink_count++;
            sink_hold = ((sink_count / 48) % 4 == 1) ? 0 : int'($urandom_range(0, 3));
            sink_ready <= (sink_hold == 0);
        end else if (!sink_ready) begin
            if (sink_hold > 0) sink_hold--;
            sink_ready <= (sink_hold == 0);
        end
    end

    initial begin
        t_flash_req        rq;
        bit                noise;
        int                item_no;
        sfcs_pkg::t_result done_res;

        in_if.valid      <= 1'b0;
        in_if.func       <= sfcs_pkg::FUNC_START;
        in_if.op         <= sfcs_pkg::OP_WRSR;
        in_if.flash_addr <= '0;
        in_if.byte_count <= '0;
        in_if.byte_value <= '0;
        done_res = done_result();

        // Ignored transfers while idle.
        add_row(sfcs_pkg::FUNC_SPI,  sfcs_pkg::OP_WRSR,  24'h000000, 16'h0000, 8'hFF, 0, '0);
        add_row(sfcs_pkg::FUNC_HOST, sfcs_pkg::OP_PROG,  24'hFFFFFF, 16'hFFFF, 8'h00, 0, '0);
        add_row(FUNC_UNUSED,         sfcs_pkg::OP_ERASE, 24'hFFFFFF, 16'hFFFF, 8'hFF, 0, '0);
        // Zero-length read at the top address, with a start arriving while busy.
        add_row(sfcs_pkg::FUNC_START, sfcs_pkg::OP_READ, 24'hFFFFFF, 16'h0000, 8'h5A, 1,
                pack_result(sfcs_pkg::KIND_XFER, sfcs_pkg::CMD_FREAD, 1'b0, 8'h00, 1'b1));
        add_row(sfcs_pkg::FUNC_START, sfcs_pkg::OP_ERASE, 24'h123456, 16'h0001, 8'h00, 0, '0);
        repeat (3)
            add_row(sfcs_pkg::FUNC_SPI, sfcs_pkg::OP_WRSR, 24'h0, 16'h0, 8'h00, PREDICTED, '0);
        add_row(sfcs_pkg::FUNC_SPI, sfcs_pkg::OP_WRSR, 24'h0, 16'h0, 8'h00, 1,
                pack_result(sfcs_pkg::KIND_XFER, sfcs_pkg::BYTE_IDLE, 1'b1, 8'h00, 1'b1));
        add_row(sfcs_pkg::FUNC_SPI, sfcs_pkg::OP_WRSR, 24'h0, 16'h0, 8'hA5, 1, done_res);
        // Zero-length program at address zero: WEL clear once, WIP set once.
        add_row(sfcs_pkg::FUNC_START, sfcs_pkg::OP_PROG, 24'h000000, 16'h0000, 8'hFF, 1,
                pack_result(sfcs_pkg::KIND_XFER, sfcs_pkg::CMD_WREN, 1'b1, 8'h00, 1'b1));
        add_row(sfcs_pkg::FUNC_HOST, sfcs_pkg::OP_WRSR, 24'h0, 16'h0, 8'hAA, 0, '0);
        repeat (2)
            add_row(sfcs_pkg::FUNC_SPI, sfcs_pkg::OP_WRSR, 24'h0, 16'h0, 8'h00, PREDICTED, '0);
        add_row(sfcs_pkg::FUNC_SPI, sfcs_pkg::OP_WRSR, 24'h0, 16'h0, 8'hFD, PREDICTED, '0);
        add_row(sfcs_pkg::FUNC_SPI, sfcs_pkg::OP_WRSR, 24'h0, 16'h0, 8'h00, PREDICTED, '0);
        add_row(sfcs_pkg::FUNC_SPI, sfcs_pkg::OP_WRSR, 24'h0, 16'h0, 8'h02, PREDICTED, '0);
        repeat (5)
            add_row(sfcs_pkg::FUNC_SPI, sfcs_pkg::OP_WRSR, 24'h0, 16'h0, 8'h00, PREDICTED, '0);
        add_row(sfcs_pkg::FUNC_SPI, sfcs_pkg::OP_WRSR, 24'h0, 16'h0, 8'h01, PREDICTED, '0);
        add_row(sfcs_pkg::FUNC_SPI, sfcs_pkg::OP_WRSR, 24'h0, 16'h0, 8'h00, PREDICTED, '0);
        add_row(sfcs_pkg::FUNC_SPI, sfcs_pkg::OP_WRSR, 24'h0, 16'h0, 8'hFE, 1, done_res);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stim_table[k]) begin
            drive_request(stim_table[k].req, 1'b0);
            record_request(stim_table[k].req, stim_table[k].typed, stim_table[k].res);
        end

        // Random operations; roughly one transfer in ten is noise.
        item_no = 0;
        while (item_no < RANDOM_ITEMS) begin
            noise = ($urandom_range(0, 9) == 0);
            rq    = next_request(noise);
            drive_request(rq, (item_no / 64) % 4 == 2);
            record_request(rq, PREDICTED, '0);
            item_no++;
        end
        in_if.valid <= 1'b0;

        for (int c = 0; c < DRAIN_LIMIT && expected_results.size() != 0; c++) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (expected_results.size() != 0)
            report_mismatch("expected results left over", expected_results.size(), 0);

        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
